/* rtl/core/assert_macros.svh */
// assertion macros for the rotary position embedding block
// uses the clock and reset names of the module that includes it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle as its antecedent
`define RPE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// property holds in the cycle after its antecedent
`define RPE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/rope_pkg.sv */
// shared types, constants and constant tables of the rotary position embedding block
// no dependencies
`default_nettype none

package rope_pkg;

   // field widths
   localparam int DATA_W    = 32;
   localparam int PAIR_W    = 7;
   localparam int POS_W     = 20;
   localparam int HEAD_W    = 9;
   localparam int BASE_W    = 32;
   localparam int FRAC_BITS = 24;

   // parameter defaults
   localparam int DEF_MAX_HEAD_SIZE  = 256;
   localparam int DEF_CORDIC_STAGES  = 24;

   // configuration registers
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 1;
   localparam logic [HEAD_W-1:0] HEAD_SIZE_RESET = 9'd128;
   localparam logic [BASE_W-1:0] LOG2_BASE_RESET = 32'd222930785;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAD_SIZE = 1'b0,
      CSR_LOG2_BASE = 1'b1
   } csr_index_type;

   // exponent divider
   localparam int NUM_W      = BASE_W + PAIR_W;
   localparam int EXP_INT_W  = NUM_W - FRAC_BITS;
   localparam int DIV_W      = HEAD_W - 1;
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_PAD_W  = DIV_STAGES * DIV_STEP;

   // power of two and angle scaling
   localparam int MANT_W       = 32;
   localparam int INV_TWO_PI_W = 30;
   localparam logic [INV_TWO_PI_W-1:0] INV_TWO_PI = 30'h28BE60DB;
   localparam int SCALE_W = MANT_W + INV_TWO_PI_W - FRAC_BITS;
   localparam int PROD_W  = POS_W + SCALE_W;
   localparam int ANG_W   = 32;

   // cordic and rotation
   localparam int CW = 34;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
   localparam int MUL_W = DATA_W + CW;
   localparam int ACC_W = MUL_W + 2;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_low;
      logic signed [DATA_W-1:0] x_high;
   } pair_type;

   typedef struct packed {
      logic [PAIR_W-1:0]        pair_index;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] x_low;
      logic signed [DATA_W-1:0] x_high;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] y_low;
      logic signed [DATA_W-1:0] y_high;
   } rsp_type;

   typedef struct packed {
      logic [NUM_W-1:0] expo;
      logic [POS_W-1:0] position;
      pair_type         pair;
   } exp_type;

   typedef struct packed {
      logic [ANG_W-1:0] angle;
      pair_type         pair;
   } ang_type;

   typedef struct packed {
      logic signed [CW-1:0] cos_v;
      logic signed [CW-1:0] sin_v;
      logic                 flip;
      pair_type             pair;
   } rot_type;

   // arctangent of 2^-i in binary angle units, 2^32 per turn
   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] a;
      case (i)
         0:  a = 32'h20000000;
         1:  a = 32'h12E4051E;
         2:  a = 32'h09FB385B;
         3:  a = 32'h051111D4;
         4:  a = 32'h028B0D43;
         5:  a = 32'h0145D7E1;
         6:  a = 32'h00A2F61E;
         7:  a = 32'h00517C55;
         8:  a = 32'h0028BE53;
         9:  a = 32'h00145F2F;
         10: a = 32'h000A2F98;
         11: a = 32'h000517CC;
         12: a = 32'h00028BE6;
         13: a = 32'h000145F3;
         14: a = 32'h0000A2FA;
         15: a = 32'h0000517D;
         16: a = 32'h000028BE;
         17: a = 32'h0000145F;
         18: a = 32'h00000A30;
         19: a = 32'h00000518;
         20: a = 32'h0000028C;
         21: a = 32'h00000146;
         22: a = 32'h000000A3;
         23: a = 32'h00000051;
         24: a = 32'h00000029;
         25: a = 32'h00000014;
         26: a = 32'h0000000A;
         27: a = 32'h00000005;
         28: a = 32'h00000003;
         29: a = 32'h00000001;
         30: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

   // integer square root, evaluated at elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] t;
      r = '0;
      b = 64'h0000_0000_8000_0000;
      for (int j = 0; j < 32; j++) begin
         t = r | b;
         if (t * t <= v) r = t;
         b = b >> 1;
      end
      return r;
   endfunction

   // 2^(-2^-i) in q0.32 by repeated square roots, i from 1
   function automatic logic [31:0] root_val(input int i);
      logic [63:0] r;
      r = 64'h0000_0000_8000_0000;
      for (int j = 1; j <= i; j++) begin
         r = isqrt64(r << 32);
      end
      return r[31:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/rpe_divider.sv */
// pipelined exponent divider: log2_base * k / (head_size / 2), four quotient bits a stage
// depends on rope_pkg
`default_nettype none

module rpe_divider import rope_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [BASE_W-1:0] log2_base,
   input  logic [DIV_W-1:0]  divisor,
   input  logic              in_valid,
   output logic              in_ready,
   input  req_type           in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output exp_type           out_data
);

   localparam int S = DIV_STAGES + 1;

   logic                 valid_ff [S];
   logic                 rdy      [S+1];
   logic [DIV_W-1:0]     rem_ff   [S];
   logic [DIV_PAD_W-1:0] nq_ff    [S];
   logic [POS_W-1:0]     pos_ff   [S];
   pair_type             pair_ff  [S];
   logic [DIV_PAD_W-1:0] num_in;

   // stall chain, a stage moves when empty or when the next one moves
   assign rdy[S] = out_ready;
   for (genvar g = 0; g < S; g++) begin : g_rdy
      assign rdy[g] = ~valid_ff[g] | rdy[g+1];
   end
   assign in_ready = rdy[0];

   // numerator product
   assign num_in = DIV_PAD_W'(log2_base) * DIV_PAD_W'(in_data.pair_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         rem_ff[0]         <= '0;
         nq_ff[0]          <= num_in;
         pos_ff[0]         <= in_data.position;
         pair_ff[0].x_low  <= in_data.x_low;
         pair_ff[0].x_high <= in_data.x_high;
      end
   end

   // restoring division, quotient bits shift in as numerator bits shift out
   for (genvar g = 1; g < S; g++) begin : g_div
      logic [DIV_W-1:0]     rem_in;
      logic [DIV_PAD_W-1:0] nq_in;

      always_comb begin
         logic [DIV_W:0] r9;
         logic           ge;
         rem_in = rem_ff[g-1];
         nq_in  = nq_ff[g-1];
         for (int j = 0; j < DIV_STEP; j++) begin
            r9     = {rem_in, nq_in[DIV_PAD_W-1]};
            ge     = (r9 >= {1'b0, divisor});
            nq_in  = {nq_in[DIV_PAD_W-2:0], ge};
            rem_in = ge ? DIV_W'(r9 - {1'b0, divisor}) : r9[DIV_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            valid_ff[g] <= valid_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[g] && valid_ff[g-1]) begin
            rem_ff[g]  <= rem_in;
            nq_ff[g]   <= nq_in;
            pos_ff[g]  <= pos_ff[g-1];
            pair_ff[g] <= pair_ff[g-1];
         end
      end
   end

   assign out_valid         = valid_ff[S-1];
   assign out_data.expo     = nq_ff[S-1][NUM_W-1:0];
   assign out_data.position = pos_ff[S-1];
   assign out_data.pair     = pair_ff[S-1];

endmodule

`default_nettype wire

/* rtl/core/rpe_angle.sv */
// angle pipeline: power of two by root table products, scale by 1/(2*pi), times position
// depends on rope_pkg
`default_nettype none

module rpe_angle import rope_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  exp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output ang_type out_data
);

   localparam int MS = FRAC_BITS;
   localparam int S  = MS + 3;

   logic                 valid_ff [S];
   logic                 rdy      [S+1];
   pair_type             pair_ff  [S];
   logic [MANT_W-1:0]    mant_ff  [MS];
   logic                 unity_ff [MS];
   logic [FRAC_BITS-1:0] frac_ff  [MS];
   logic [EXP_INT_W-1:0] nexp_ff  [MS+2];
   logic [POS_W-1:0]     pos_ff   [MS+1];
   logic [SCALE_W-1:0]   scale_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [ANG_W-1:0]     angle_ff;

   // stall chain
   assign rdy[S] = out_ready;
   for (genvar g = 0; g < S; g++) begin : g_rdy
      assign rdy[g] = ~valid_ff[g] | rdy[g+1];
   end
   assign in_ready = rdy[0];

   // one root product a stage; a mantissa of exactly one is kept as a flag
   for (genvar g = 0; g < MS; g++) begin : g_mant
      localparam logic [MANT_W-1:0] ROOT = root_val(g + 1);

      logic                 src_valid;
      logic [MANT_W-1:0]    src_mant;
      logic                 src_unity;
      logic [FRAC_BITS-1:0] src_frac;
      logic [EXP_INT_W-1:0] src_nexp;
      logic [POS_W-1:0]     src_pos;
      pair_type             src_pair;
      logic [2*MANT_W-1:0]  prod;
      logic [MANT_W-1:0]    mant_in;
      logic                 unity_in;

      if (g == 0) begin : g_src
         assign src_valid = in_valid;
         assign src_mant  = '0;
         assign src_unity = 1'b1;
         assign src_frac  = in_data.expo[FRAC_BITS-1:0];
         assign src_nexp  = in_data.expo[NUM_W-1:FRAC_BITS];
         assign src_pos   = in_data.position;
         assign src_pair  = in_data.pair;
      end else begin : g_src
         assign src_valid = valid_ff[g-1];
         assign src_mant  = mant_ff[g-1];
         assign src_unity = unity_ff[g-1];
         assign src_frac  = frac_ff[g-1];
         assign src_nexp  = nexp_ff[g-1];
         assign src_pos   = pos_ff[g-1];
         assign src_pair  = pair_ff[g-1];
      end

      assign prod = (2*MANT_W)'(src_mant) * (2*MANT_W)'(ROOT);

      always_comb begin
         mant_in  = src_mant;
         unity_in = src_unity;
         if (src_frac[FRAC_BITS-1-g]) begin
            mant_in  = src_unity ? ROOT : prod[2*MANT_W-1:MANT_W];
            unity_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            valid_ff[g] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[g] && src_valid) begin
            mant_ff[g]  <= mant_in;
            unity_ff[g] <= unity_in;
            frac_ff[g]  <= src_frac;
            nexp_ff[g]  <= src_nexp;
            pos_ff[g]   <= src_pos;
            pair_ff[g]  <= src_pair;
         end
      end
   end

   // scale to turns per position step
   logic [MANT_W+INV_TWO_PI_W-1:0] sprod;
   logic [SCALE_W-1:0]             scale_in;
   assign sprod    = (MANT_W+INV_TWO_PI_W)'(mant_ff[MS-1]) * (MANT_W+INV_TWO_PI_W)'(INV_TWO_PI);
   assign scale_in = unity_ff[MS-1] ? {INV_TWO_PI, 8'b0}
                                    : sprod[MANT_W+INV_TWO_PI_W-1:FRAC_BITS];

   // position product
   logic [PROD_W-1:0] prod_in;
   assign prod_in = PROD_W'(pos_ff[MS]) * PROD_W'(scale_ff);

   // shift by integer exponent, huge exponents give a zero angle
   logic [EXP_INT_W:0] shamt;
   logic [ANG_W-1:0]   angle_in;
   assign shamt    = {1'b0, nexp_ff[MS+1]} + (EXP_INT_W+1)'(8);
   assign angle_in = (shamt >= (EXP_INT_W+1)'(64)) ? '0 : ANG_W'(prod_ff >> shamt[5:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[MS]   <= 1'b0;
         valid_ff[MS+1] <= 1'b0;
         valid_ff[MS+2] <= 1'b0;
      end else begin
         if (rdy[MS])   valid_ff[MS]   <= valid_ff[MS-1];
         if (rdy[MS+1]) valid_ff[MS+1] <= valid_ff[MS];
         if (rdy[MS+2]) valid_ff[MS+2] <= valid_ff[MS+1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[MS] && valid_ff[MS-1]) begin
         scale_ff    <= scale_in;
         nexp_ff[MS] <= nexp_ff[MS-1];
         pos_ff[MS]  <= pos_ff[MS-1];
         pair_ff[MS] <= pair_ff[MS-1];
      end
      if (rdy[MS+1] && valid_ff[MS]) begin
         prod_ff       <= prod_in;
         nexp_ff[MS+1] <= nexp_ff[MS];
         pair_ff[MS+1] <= pair_ff[MS];
      end
      if (rdy[MS+2] && valid_ff[MS+1]) begin
         angle_ff      <= angle_in;
         pair_ff[MS+2] <= pair_ff[MS+1];
      end
   end

   assign out_valid      = valid_ff[S-1];
   assign out_data.angle = angle_ff;
   assign out_data.pair  = pair_ff[S-1];

endmodule

`default_nettype wire

/* rtl/core/rpe_cordic.sv */
// rotation-mode cordic, one iteration a stage, after a fold into half a turn around zero
// depends on rope_pkg
`default_nettype none

module rpe_cordic import rope_pkg::*; #(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  ang_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rot_type out_data
);

   localparam int S = CORDIC_STAGES + 1;

   logic                 valid_ff [S];
   logic                 rdy      [S+1];
   logic signed [CW-1:0] x_ff     [S];
   logic signed [CW-1:0] y_ff     [S];
   logic signed [CW-1:0] z_ff     [S];
   logic                 flip_ff  [S];
   pair_type             pair_ff  [S];

   // stall chain
   assign rdy[S] = out_ready;
   for (genvar g = 0; g < S; g++) begin : g_rdy
      assign rdy[g] = ~valid_ff[g] | rdy[g+1];
   end
   assign in_ready = rdy[0];

   // fold second and third quadrants by half a turn
   logic             flip_in;
   logic [ANG_W-1:0] fold_ang;
   assign flip_in  = in_data.angle[ANG_W-1] ^ in_data.angle[ANG_W-2];
   assign fold_ang = in_data.angle ^ {flip_in, {(ANG_W-1){1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= {{(CW-ANG_W){fold_ang[ANG_W-1]}}, fold_ang};
         flip_ff[0] <= flip_in;
         pair_ff[0] <= in_data.pair;
      end
   end

   // micro-rotations
   for (genvar g = 1; g < S; g++) begin : g_iter
      localparam logic [CW-1:0] ATAN = CW'(atan_turn(g - 1));

      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [CW-1:0] x_in;
      logic signed [CW-1:0] y_in;
      logic signed [CW-1:0] z_in;

      assign dx = y_ff[g-1] >>> (g - 1);
      assign dy = x_ff[g-1] >>> (g - 1);

      always_comb begin
         if (!z_ff[g-1][CW-1]) begin
            x_in = x_ff[g-1] - dx;
            y_in = y_ff[g-1] + dy;
            z_in = z_ff[g-1] - signed'(ATAN);
         end else begin
            x_in = x_ff[g-1] + dx;
            y_in = y_ff[g-1] - dy;
            z_in = z_ff[g-1] + signed'(ATAN);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            valid_ff[g] <= valid_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[g] && valid_ff[g-1]) begin
            x_ff[g]    <= x_in;
            y_ff[g]    <= y_in;
            z_ff[g]    <= z_in;
            flip_ff[g] <= flip_ff[g-1];
            pair_ff[g] <= pair_ff[g-1];
         end
      end
   end

   assign out_valid      = valid_ff[S-1];
   assign out_data.cos_v = x_ff[S-1];
   assign out_data.sin_v = y_ff[S-1];
   assign out_data.flip  = flip_ff[S-1];
   assign out_data.pair  = pair_ff[S-1];

endmodule

`default_nettype wire

/* rtl/core/rpe_rotate.sv */
// pair rotation: four products, sum and sign, then round to q16.16 and saturate
// depends on rope_pkg
`default_nettype none

module rpe_rotate import rope_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rot_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic mul_valid_ff;
   logic sum_valid_ff;
   logic out_valid_ff;
   logic mul_rdy;
   logic sum_rdy;
   logic out_rdy;

   logic signed [MUL_W-1:0] lc_ff;
   logic signed [MUL_W-1:0] hs_ff;
   logic signed [MUL_W-1:0] hc_ff;
   logic signed [MUL_W-1:0] ls_ff;
   logic                    flip_ff;
   logic signed [ACC_W-1:0] acc_low_ff;
   logic signed [ACC_W-1:0] acc_high_ff;
   rsp_type                 out_ff;

   logic signed [ACC_W-1:0] acc_low_in;
   logic signed [ACC_W-1:0] acc_high_in;
   rsp_type                 out_in;

   // round half up at bit 30, then clamp to 32 bits
   function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0]  t;
      logic [ACC_W-DATA_W:0]    hi;
      logic signed [DATA_W-1:0] r;
      t  = (acc + (ACC_W'(1) <<< 29)) >>> 30;
      hi = t[ACC_W-1:DATA_W-1];
      if (&hi || ~|hi) begin
         r = t[DATA_W-1:0];
      end else begin
         r = t[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   // stall chain
   assign out_rdy  = ~out_valid_ff | out_ready;
   assign sum_rdy  = ~sum_valid_ff | out_rdy;
   assign mul_rdy  = ~mul_valid_ff | sum_rdy;
   assign in_ready = mul_rdy;

   // sums, negated for folded angles
   always_comb begin
      acc_low_in  = ACC_W'(lc_ff) - ACC_W'(hs_ff);
      acc_high_in = ACC_W'(hc_ff) + ACC_W'(ls_ff);
      if (flip_ff) begin
         acc_low_in  = -acc_low_in;
         acc_high_in = -acc_high_in;
      end
   end

   assign out_in.y_low  = round_sat(acc_low_ff);
   assign out_in.y_high = round_sat(acc_high_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (mul_rdy) mul_valid_ff <= in_valid;
         if (sum_rdy) sum_valid_ff <= mul_valid_ff;
         if (out_rdy) out_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_rdy && in_valid) begin
         lc_ff   <= MUL_W'(in_data.pair.x_low)  * MUL_W'(in_data.cos_v);
         hs_ff   <= MUL_W'(in_data.pair.x_high) * MUL_W'(in_data.sin_v);
         hc_ff   <= MUL_W'(in_data.pair.x_high) * MUL_W'(in_data.cos_v);
         ls_ff   <= MUL_W'(in_data.pair.x_low)  * MUL_W'(in_data.sin_v);
         flip_ff <= in_data.flip;
      end
      if (sum_rdy && mul_valid_ff) begin
         acc_low_ff  <= acc_low_in;
         acc_high_ff <= acc_high_in;
      end
      if (out_rdy && sum_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

`default_nettype wire

/* rtl/core/rotary_position_embedding.sv */
// top level of the rotary position embedding block: registers and the four pipeline parts
// depends on rope_pkg, rpe_divider, rpe_angle, rpe_cordic, rpe_rotate, assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

// Takes one item per clock while req_ready is high: a rotation pair x_low, x_high
// with its pair index and token position, and returns the pair rotated by
// position * base^(-2k/head_size), rounded to Q16.16 and saturated. Items pass the
// exponent divider (four quotient bits per stage), the angle stages (24 root
// products, scale, position product, shift), the cordic and rotate stages. Each
// stage holds its own valid bit, so a stalled result only backs up the stages behind
// it and empty stages keep filling. The user must write head_size and log2_base
// via the csr port only while no item is in flight; the block does not enforce it.
module rotary_position_embedding import rope_pkg::*; #(
   parameter int MAX_HEAD_SIZE = DEF_MAX_HEAD_SIZE,
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   localparam int HMAX_RAW = (MAX_HEAD_SIZE / 2) * 2;
   localparam int HMAX     = (HMAX_RAW < 2) ? 2 : HMAX_RAW;
   localparam int HMAX_CAP = (HMAX > 510) ? 510 : HMAX;
   localparam logic [HEAD_W-1:0] HMAX_H = HEAD_W'(HMAX_CAP);

   logic [HEAD_W-1:0] head_size_ff;
   logic [BASE_W-1:0] log2_base_ff;
   logic [HEAD_W-1:0] head_even;
   logic [HEAD_W-1:0] head_lim;
   logic [DIV_W-1:0]  divisor;

   logic    div_valid;
   logic    div_ready;
   exp_type div_data;
   logic    ang_valid;
   logic    ang_ready;
   ang_type ang_data;
   logic    rot_valid;
   logic    rot_ready;
   rot_type rot_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_size_ff <= HEAD_SIZE_RESET;
         log2_base_ff <= LOG2_BASE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEAD_SIZE: head_size_ff <= csr_write_data[HEAD_W-1:0];
            CSR_LOG2_BASE: log2_base_ff <= csr_write_data[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // even head size clamped to its legal range, half of it divides
   assign head_even = {head_size_ff[HEAD_W-1:1], 1'b0};
   always_comb begin
      if (head_even < HEAD_W'(2)) begin
         head_lim = HEAD_W'(2);
      end else if (head_even > HMAX_H) begin
         head_lim = HMAX_H;
      end else begin
         head_lim = head_even;
      end
   end
   assign divisor = head_lim[HEAD_W-1:1];

   rpe_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .log2_base (log2_base_ff),
      .divisor   (divisor),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   rpe_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (ang_valid),
      .out_ready (ang_ready),
      .out_data  (ang_data)
   );

   rpe_cordic #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ang_valid),
      .in_ready  (ang_ready),
      .in_data   (ang_data),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_data  (rot_data)
   );

   rpe_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_ready  (rot_ready),
      .in_data   (rot_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // input only stalls when the whole pipe is backed up behind a waiting result
   `RPE_ASSERT_SAME(a_stall_needs_full, !req_ready, rsp_valid && !rsp_ready, "input stalled with output free")
   // a stalled item between divider and angle stages holds
   `RPE_ASSERT_NEXT(a_div_hold, div_valid && !div_ready, div_valid && $stable(div_data), "divider item lost")
   // nothing comes out right after reset
   `RPE_ASSERT_SAME(a_reset_empty, $past(reset), !rsp_valid, "result right after reset")

endmodule

`default_nettype wire
